// ----- rtl/cfws_pkg.sv -----
// shared types and constants for the circular fifo with search
`default_nettype none

package cfws_pkg;

  localparam int DataW        = 32;
  localparam int DepthDefault = 16;

  typedef enum logic [1:0] {
    OP_ENQUEUE = 2'd0,
    OP_DEQUEUE = 2'd1,
    OP_SEARCH  = 2'd2,
    OP_CLEAR   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_EMPTY = 2'd2
  } err_e;

  typedef struct packed {
    logic enq;
    logic deq;
    logic srch;
    logic clr;
    logic load_imm;
    logic pop_done;
    logic srch_step;
    logic srch_done;
  } ctl_cmd_t;

  typedef struct packed {
    logic out_busy;
    logic empty;
    logic last_one;
    logic hit;
    logic left_zero;
  } ctl_sts_t;

endpackage

`default_nettype wire

// ----- rtl/circular_fifo_with_search_core.sv -----
// top level of the circular fifo with search
`default_nettype none

// Ring-buffer queue of signed 32-bit words, up to DEPTH entries, one result per
// input transfer. Enqueue, clear, a refused push or pop and a search of an empty
// queue load their result at the edge that takes the item. A dequeue that
// leaves entries behind first passes through a pop state, since the new head
// word comes from the single registered read port of the storage. A search
// walks the queued entries through that same read port, one per cycle, and
// stops at the first match or after the last entry. One item is in work at a
// time; while a result waits in the output register the input is stalled, and
// the next item is taken no earlier than the edge at which that result is
// transferred. Reset clears no storage, and clear only resets pointers and count.
module circular_fifo_with_search_core #(
  parameter int DEPTH = cfws_pkg::DepthDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        op_i,
  input  logic signed [cfws_pkg::DataW-1:0] value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [cfws_pkg::DataW-1:0] data_out_o,
  output logic                              found_o,
  output logic [1:0]                        error_code_o,
  output logic [$clog2(DEPTH+1)-1:0]        entry_count_o,
  output logic                              is_empty_o,
  output logic                              is_full_o,
  output logic signed [cfws_pkg::DataW-1:0] head_value_o
);
  import cfws_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  cfws_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .op_i       (op_i),
    .sts_i      (sts),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  cfws_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .data_out_o    (data_out_o),
    .found_o       (found_o),
    .error_code_o  (error_code_o),
    .entry_count_o (entry_count_o),
    .is_empty_o    (is_empty_o),
    .is_full_o     (is_full_o),
    .head_value_o  (head_value_o)
  );

`ifndef NO_ASSERTIONS
  a_full_err_keeps_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (error_code_o == ERR_FULL) |-> is_full_o)
    else $error("refused push did not leave the queue full");

  a_empty_err_keeps_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (error_code_o == ERR_EMPTY) |-> is_empty_o && (data_out_o == '0))
    else $error("refused pop did not leave the queue empty");

  a_no_load_while_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.out_busy |-> !(cmd.load_imm || cmd.pop_done || cmd.srch_done))
    else $error("result register overwritten while a transfer waits");

  a_found_only_when_queued : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> !is_empty_o)
    else $error("search hit reported on an empty queue");
`endif

endmodule

`default_nettype wire

// ----- rtl/cfws_ctrl.sv -----
// controller state machine for the circular fifo with search
`default_nettype none

module cfws_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [1:0]          op_i,
  input  cfws_pkg::ctl_sts_t  sts_i,
  output logic                in_stall_o,
  output cfws_pkg::ctl_cmd_t  cmd_o
);
  import cfws_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_SEARCH
  } state_e;

  state_e state_q, state_d;
  logic   acc;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    acc        = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = sts_i.out_busy;
        acc        = in_valid_i && !sts_i.out_busy;
        if (acc) begin
          unique case (op_i)
            OP_ENQUEUE: begin
              cmd_o.enq      = 1'b1;
              cmd_o.load_imm = 1'b1;
            end
            OP_DEQUEUE: begin
              cmd_o.deq = 1'b1;
              if (sts_i.empty || sts_i.last_one) begin
                cmd_o.load_imm = 1'b1;
              end else begin
                state_d = S_POP;
              end
            end
            OP_SEARCH: begin
              cmd_o.srch = 1'b1;
              if (sts_i.empty) begin
                cmd_o.load_imm = 1'b1;
              end else begin
                state_d = S_SEARCH;
              end
            end
            default: begin
              cmd_o.clr      = 1'b1;
              cmd_o.load_imm = 1'b1;
            end
          endcase
        end
      end
      S_POP: begin
        cmd_o.pop_done = 1'b1;
        state_d        = S_IDLE;
      end
      S_SEARCH: begin
        if (sts_i.hit || sts_i.left_zero) begin
          cmd_o.srch_done = 1'b1;
          state_d         = S_IDLE;
        end else begin
          cmd_o.srch_step = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/cfws_dp.sv -----
// datapath of the circular fifo with search: storage, pointers and result register
`default_nettype none

module cfws_dp #(
  parameter int DEPTH = cfws_pkg::DepthDefault
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  cfws_pkg::ctl_cmd_t                   cmd_i,
  output cfws_pkg::ctl_sts_t                   sts_o,
  input  logic signed [cfws_pkg::DataW-1:0]    value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [cfws_pkg::DataW-1:0]    data_out_o,
  output logic                                 found_o,
  output logic [1:0]                           error_code_o,
  output logic [$clog2(DEPTH+1)-1:0]           entry_count_o,
  output logic                                 is_empty_o,
  output logic                                 is_full_o,
  output logic signed [cfws_pkg::DataW-1:0]    head_value_o
);
  import cfws_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FullCnt = CW'(DEPTH);
  localparam logic [CW-1:0] OneCnt  = CW'(1);

  function automatic logic [AW-1:0] nxt(input logic [AW-1:0] p);
    nxt = (p == LastIdx) ? '0 : p + AW'(1);
  endfunction

  logic signed [DataW-1:0] mem [DEPTH];
  logic signed [DataW-1:0] rd_data_q;
  logic [AW-1:0]           rd_addr;

  logic [AW-1:0]           head_ptr_q, head_ptr_d;
  logic [AW-1:0]           tail_ptr_q, tail_ptr_d;
  logic [CW-1:0]           count_q, count_d;
  logic signed [DataW-1:0] head_word_q, head_word_d;
  logic signed [DataW-1:0] removed_q;
  logic signed [DataW-1:0] key_q;
  logic [AW-1:0]           srch_ptr_q;
  logic [CW-1:0]           left_q;

  logic                    empty, full, hit, load, push_ok, pop_ok;
  logic signed [DataW-1:0] res_data, res_head;
  logic                    res_found;
  logic [1:0]              res_err;

  assign empty   = (count_q == '0);
  assign full    = (count_q == FullCnt);
  assign hit     = (rd_data_q == key_q);
  assign push_ok = cmd_i.enq && !full;
  assign pop_ok  = cmd_i.deq && !empty;
  assign load    = cmd_i.load_imm || cmd_i.pop_done || cmd_i.srch_done;

  assign sts_o.out_busy  = out_valid_o && out_stall_i;
  assign sts_o.empty     = empty;
  assign sts_o.last_one  = (count_q == OneCnt);
  assign sts_o.hit       = hit;
  assign sts_o.left_zero = (left_q == '0);

  always_comb begin
    if (cmd_i.deq) begin
      rd_addr = nxt(head_ptr_q);
    end else if (cmd_i.srch) begin
      rd_addr = head_ptr_q;
    end else begin
      rd_addr = srch_ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem[tail_ptr_q] <= value_i;
    end
    rd_data_q <= mem[rd_addr];
  end

  always_comb begin
    head_ptr_d  = head_ptr_q;
    tail_ptr_d  = tail_ptr_q;
    count_d     = count_q;
    head_word_d = head_word_q;
    if (push_ok) begin
      tail_ptr_d = nxt(tail_ptr_q);
      count_d    = count_q + OneCnt;
      if (empty) begin
        head_word_d = value_i;
      end
    end
    if (pop_ok) begin
      head_ptr_d = nxt(head_ptr_q);
      count_d    = count_q - OneCnt;
    end
    if (cmd_i.clr) begin
      head_ptr_d = '0;
      tail_ptr_d = '0;
      count_d    = '0;
    end
    if (cmd_i.pop_done) begin
      head_word_d = rd_data_q;
    end
  end

  always_comb begin
    res_data  = '0;
    res_found = 1'b0;
    res_err   = ERR_OK;
    res_head  = (count_d == '0) ? '0 : head_word_d;
    if (cmd_i.enq && full) begin
      res_err = ERR_FULL;
    end
    if (cmd_i.deq && empty) begin
      res_err = ERR_EMPTY;
    end
    if (pop_ok) begin
      res_data = head_word_q;
    end
    if (cmd_i.pop_done) begin
      res_data = removed_q;
    end
    if (cmd_i.srch_done) begin
      res_found = hit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_ptr_q  <= '0;
      tail_ptr_q  <= '0;
      count_q     <= '0;
      out_valid_o <= 1'b0;
    end else begin
      head_ptr_q <= head_ptr_d;
      tail_ptr_q <= tail_ptr_d;
      count_q    <= count_d;
      if (load) begin
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    head_word_q <= head_word_d;
    if (pop_ok) begin
      removed_q <= head_word_q;
    end
    if (cmd_i.srch) begin
      key_q      <= value_i;
      srch_ptr_q <= nxt(head_ptr_q);
      left_q     <= count_q - OneCnt;
    end else if (cmd_i.srch_step) begin
      srch_ptr_q <= nxt(srch_ptr_q);
      left_q     <= left_q - OneCnt;
    end
    if (load) begin
      data_out_o    <= res_data;
      found_o       <= res_found;
      error_code_o  <= res_err;
      entry_count_o <= count_d;
      is_empty_o    <= (count_d == '0);
      is_full_o     <= (count_d == FullCnt);
      head_value_o  <= res_head;
    end
  end

endmodule

`default_nettype wire

// ----- tb/cfws_checker.sv -----
// checker that predicts and compares every result of the circular fifo with search
`timescale 1ns / 1ps

module cfws_checker #(
  parameter int DEPTH = cfws_pkg::DepthDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_stall_i,
  input  logic [1:0]                        op_i,
  input  logic signed [cfws_pkg::DataW-1:0] value_i,
  input  logic                              out_valid_i,
  input  logic                              out_stall_i,
  input  logic signed [cfws_pkg::DataW-1:0] data_out_i,
  input  logic                              found_i,
  input  logic [1:0]                        error_code_i,
  input  logic [$clog2(DEPTH+1)-1:0]        entry_count_i,
  input  logic                              is_empty_i,
  input  logic                              is_full_i,
  input  logic signed [cfws_pkg::DataW-1:0] head_value_i,
  output int                                failures_o,
  output int                                pending_o
);
  import cfws_pkg::*;

  localparam int CountW = $clog2(DEPTH + 1);

  typedef struct {
    logic signed [DataW-1:0] data_out;
    logic                    found;
    err_e                    error_code;
    logic [CountW-1:0]       entry_count;
    logic                    is_empty;
    logic                    is_full;
    logic signed [DataW-1:0] head_value;
  } fifo_result_t;

  fifo_result_t            awaited_results[$];
  logic signed [DataW-1:0] word_mem [DEPTH];
  int                      rd_idx;
  int                      wr_idx;
  int                      fill;

  function automatic fifo_result_t predict_fifo_result(op_e kind, logic signed [DataW-1:0] word);
    fifo_result_t res;
    int           idx;
    res.data_out   = '0;
    res.found      = 1'b0;
    res.error_code = ERR_OK;
    case (kind)
      OP_ENQUEUE: begin
        if (fill >= DEPTH) begin
          res.error_code = ERR_FULL;
        end else begin
          word_mem[wr_idx] = word;
          wr_idx = (wr_idx + 1) % DEPTH;
          fill++;
        end
      end
      OP_DEQUEUE: begin
        if (fill == 0) begin
          res.error_code = ERR_EMPTY;
        end else begin
          res.data_out = word_mem[rd_idx];
          rd_idx = (rd_idx + 1) % DEPTH;
          fill--;
        end
      end
      OP_SEARCH: begin
        idx = rd_idx;
        for (int n = 0; n < fill; n++) begin
          if (word_mem[idx] == word) res.found = 1'b1;
          idx = (idx + 1) % DEPTH;
        end
      end
      default: begin
        rd_idx = 0;
        wr_idx = 0;
        fill   = 0;
      end
    endcase
    res.entry_count = CountW'(fill);
    res.is_empty    = (fill == 0);
    res.is_full     = (fill == DEPTH);
    res.head_value  = (fill != 0) ? word_mem[rd_idx] : '0;
    return res;
  endfunction

  task automatic check_field(string field, logic [DataW-1:0] want, logic [DataW-1:0] got);
    if (got !== want) begin
      failures_o++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    fifo_result_t want;
    if (!rst_ni) begin
      rd_idx     = 0;
      wr_idx     = 0;
      fill       = 0;
      failures_o = 0;
      awaited_results.delete();
      foreach (word_mem[i]) word_mem[i] = '0;
    end else begin
      // a result never belongs to an item taken at the same edge
      if (out_valid_i && !out_stall_i) begin
        if (awaited_results.size() == 0) begin
          failures_o++;
          $display("%0t: result with none expected, expected nothing actual data_out %0h",
                   $time, data_out_i);
        end else begin
          want = awaited_results.pop_front();
          check_field("data_out", want.data_out, data_out_i);
          check_field("found", DataW'(want.found), DataW'(found_i));
          check_field("error_code", DataW'(want.error_code), DataW'(error_code_i));
          check_field("entry_count", DataW'(want.entry_count), DataW'(entry_count_i));
          check_field("is_empty", DataW'(want.is_empty), DataW'(is_empty_i));
          check_field("is_full", DataW'(want.is_full), DataW'(is_full_i));
          check_field("head_value", want.head_value, head_value_i);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        awaited_results.push_back(predict_fifo_result(op_e'(op_i), value_i));
      end
    end
    pending_o = awaited_results.size();
  end

endmodule

// ----- tb/tb_circular_fifo_with_search_core.sv -----
// testbench top for the circular fifo with search: stimulus, stall patterns and verdict
`timescale 1ns / 1ps

module tb_circular_fifo_with_search_core;
  import cfws_pkg::*;

  localparam int DEPTH       = DepthDefault;
  localparam int CountW      = $clog2(DEPTH + 1);
  localparam int RandomItems = 1650;
  localparam int CycleLimit  = 400000;
  localparam int SettleCycles = 2 * DEPTH + 20;
  localparam int LongHold    = 300;

  logic                    clk       = 1'b0;
  logic                    rst_n     = 1'b0;
  logic                    in_valid  = 1'b0;
  logic                    in_stall;
  logic [1:0]              op        = OP_ENQUEUE;
  logic signed [DataW-1:0] value     = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [DataW-1:0] data_out;
  logic                    found;
  logic [1:0]              error_code;
  logic [CountW-1:0]       entry_count;
  logic                    is_empty;
  logic                    is_full;
  logic signed [DataW-1:0] head_value;

  int failures;
  int pending;
  int cycles     = 0;
  int items_sent = 0;

  logic signed [DataW-1:0] key_pool [8];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  circular_fifo_with_search_core #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .op_i         (op),
    .value_i      (value),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .data_out_o   (data_out),
    .found_o      (found),
    .error_code_o (error_code),
    .entry_count_o(entry_count),
    .is_empty_o   (is_empty),
    .is_full_o    (is_full),
    .head_value_o (head_value)
  );

  cfws_checker #(
    .DEPTH(DEPTH)
  ) i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .op_i         (op),
    .value_i      (value),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .data_out_i   (data_out),
    .found_i      (found),
    .error_code_i (error_code),
    .entry_count_i(entry_count),
    .is_empty_i   (is_empty),
    .is_full_i    (is_full),
    .head_value_i (head_value),
    .failures_o   (failures),
    .pending_o    (pending)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // one transfer, held until accepted
  task automatic send_item(op_e kind, logic signed [DataW-1:0] word);
    @(negedge clk);
    in_valid <= 1'b1;
    op       <= kind;
    value    <= word;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic idle_for(int n);
    @(negedge clk);
    in_valid <= 1'b0;
    op       <= 2'($urandom);
    value    <= $urandom;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic wait_drained();
    idle_for(1);
    while (pending != 0) @(negedge clk);
  endtask

  initial begin : receiver
    int  hold_left;
    bit  hold_done;
    int  mode;
    int  stretch;
    int  tick;
    hold_left = 0;
    hold_done = 1'b0;
    mode      = 0;
    stretch   = 0;
    tick      = 0;
    forever begin
      @(negedge clk);
      tick++;
      if (!hold_done && items_sent >= 600) begin
        hold_left = LongHold;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        if (stretch == 0) begin
          mode    = $urandom_range(0, 3);
          stretch = $urandom_range(20, 150);
        end
        stretch--;
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 9) < 7);
          default: out_stall <= (tick % 3 == 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    logic signed [DataW-1:0] word;
    logic signed [DataW-1:0] last_word;
    op_e                     kind;
    bit                      filling;
    int                      phase_left;
    int                      burst_left;
    int                      roll;

    key_pool[0] = 32'h7fffffff;
    key_pool[1] = 32'h80000000;
    key_pool[2] = 32'h00000000;
    key_pool[3] = 32'hffffffff;
    key_pool[4] = 32'h55555555;
    key_pool[5] = 32'haaaaaaaa;
    key_pool[6] = $urandom;
    key_pool[7] = $urandom;
    last_word   = '0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // refused pop and search on an empty queue
    send_item(OP_DEQUEUE, '0);
    send_item(OP_SEARCH, key_pool[2]);
    for (int i = 0; i < DEPTH; i++) begin
      word = (i < 8) ? key_pool[i] : $signed($urandom);
      last_word = word;
      send_item(OP_ENQUEUE, word);
    end
    // push when full, then searches over the full ring
    send_item(OP_ENQUEUE, 32'h13572468);
    send_item(OP_SEARCH, key_pool[0]);
    send_item(OP_SEARCH, last_word);
    send_item(OP_SEARCH, 32'h13572468);
    send_item(OP_DEQUEUE, '0);
    send_item(OP_ENQUEUE, key_pool[4]);
    send_item(OP_CLEAR, $urandom);
    send_item(OP_DEQUEUE, '0);
    wait_drained();

    filling    = 1'b0;
    phase_left = 0;
    burst_left = 0;
    for (int n = 0; n < RandomItems; n++) begin
      if (phase_left == 0) begin
        filling    = ~filling;
        phase_left = $urandom_range(30, 120);
      end
      phase_left--;
      if (n == RandomItems / 2) wait_drained();
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        if ($urandom_range(0, 3) != 0) idle_for($urandom_range(1, 6));
      end
      burst_left--;

      roll = $urandom_range(0, 99);
      if (roll < 2) begin
        kind = OP_CLEAR;
      end else if (roll < 24) begin
        kind = OP_SEARCH;
      end else if ((roll < 72) == filling) begin
        kind = OP_ENQUEUE;
      end else begin
        kind = OP_DEQUEUE;
      end
      word = ($urandom_range(0, 9) < 5) ? key_pool[$urandom_range(0, 7)] : $signed($urandom);
      send_item(kind, word);
    end

    wait_drained();
    repeat (SettleCycles) @(posedge clk);
    if (failures == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
